[rtl/pid_with_integral_clamp_assert.svh]
// ----------------------------------------------------------------------------
// pid_with_integral_clamp assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PID_WITH_INTEGRAL_CLAMP_ASSERT_SVH
`define PID_WITH_INTEGRAL_CLAMP_ASSERT_SVH

// same-cycle implication, off during reset
`define PWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked around reset
`define PWC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pwc_pkg.sv]
// ----------------------------------------------------------------------------
// pwc_pkg
// widths, register indexes and unit handshake types of the pid block
// ----------------------------------------------------------------------------
`default_nettype none

package pwc_pkg;

    localparam int GAIN_W      = 24;
    localparam int LIM_W       = 30;
    localparam int VAL_W       = 31;
    localparam int DT_W        = 16;
    localparam int DT_FRAC     = 16;
    localparam int ERR_W       = 32;
    localparam int DIFF_W      = 33;
    localparam int MUL_A_W     = 24;
    localparam int MUL_B_W     = 33;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ISUM_W      = 32;
    localparam int ISUM_RAW_W  = 34;
    localparam int SUM_W       = 63;
    localparam int D_SAT_SHIFT = 60;
    localparam int D_MAG_W     = D_SAT_SHIFT + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

`default_nettype wire

[rtl/pid_with_integral_clamp.sv]
// ----------------------------------------------------------------------------
// pid_with_integral_clamp
// one word at a time: four 24-step multiplies plus the divide
// when step_time is 0: three multiplies, no derivative product and no division
// reset: synchronous active low, ready for a word right after reset is released
// ----------------------------------------------------------------------------
`default_nettype none

// Discrete PID step in signed fixed point with an anti-windup clamp on the
// integral sum and a symmetric clamp on the control output.
//
// All products and the divide go through two narrow serial units:
//   pwc_ser_mul  shift-add multiplier, shared by the P term, the integral
//                increment, the I term and the D product
//   pwc_ser_div  restoring divider by step_time, one quotient bit a cycle,
//                72 - FRAC_BITS quotient bits
// A sequencer steps through them: P, increment, clamp, I, D product, divide,
// then the output clamp; a zero step_time skips D and the divide. Terms are
// taken as magnitude and sign so that every product truncates toward zero.
//
// Reset (synchronous, active low): gains 0, integral limit 100.0, output
// limit 500.0, integral sum and last error 0, no word pending on either side.
// There is no clearing pass; the block takes a word as soon as reset is released.
//
// One word is worked on at a time. The finished result sits in an output
// register, so the next input word is taken while it still waits.

module pid_with_integral_clamp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [30:0] target_value, [61:31] measured_value, [77:62] step_time, [79:78] zero
    input  wire logic [pwc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [30:0] control_out, [31] zero
    output logic [pwc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [pwc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pwc_pkg::LIM_W-1:0]       i_cfg_wdata
);
    import pwc_pkg::*;

    // dividend of the derivative: |gain * diff| * 2^16 / 2^F, product is < 2^56
    localparam int DIVD_W = PROD_W - 1 + DT_FRAC - FRAC_BITS;
    localparam logic [LIM_W-1:0] ILIM_RST = LIM_W'(64'd100 << FRAC_BITS);
    localparam logic [LIM_W-1:0] OLIM_RST = LIM_W'(64'd500 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_P,
        S_INC,
        S_ICLAMP,
        S_I,
        S_D,
        S_DIV,
        S_OUT
    } t_state;

    // configuration registers
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_deriv_gain;
    logic [LIM_W-1:0]  r_integ_limit;
    logic [LIM_W-1:0]  r_output_limit;

    // controller state
    t_state                   r_state;
    logic signed [ISUM_W-1:0] r_integ_sum;
    logic signed [ERR_W-1:0]  r_last_err;

    // per-word working registers
    logic [ERR_W-1:0]             r_err_mag;
    logic                         r_err_neg;
    logic [DIFF_W-1:0]            r_diff_mag;
    logic                         r_diff_neg;
    logic [DT_W-1:0]              r_dt;
    logic signed [ISUM_RAW_W-1:0] r_isum_raw;
    logic                         r_isum_neg;
    logic signed [SUM_W-1:0]      r_sum;
    t_mul_req                     r_mul_req;
    logic                         r_div_start;
    logic                         r_out_valid;
    logic [VAL_W-1:0]             r_out_data;

    // unit connections
    t_unit_sts         w_mul_sts;
    logic [PROD_W-1:0] w_prod;
    t_unit_sts         w_div_sts;
    logic [DIVD_W-1:0] w_quot;

    // input word fields
    logic signed [VAL_W-1:0] c_tgt;
    logic signed [VAL_W-1:0] c_meas;
    logic [DT_W-1:0]         c_dt;

    logic signed [ERR_W-1:0]      c_err;
    logic signed [DIFF_W-1:0]     c_diff;
    logic signed [ISUM_RAW_W-1:0] c_inc;
    logic signed [ISUM_RAW_W-1:0] c_ilim;
    logic signed [ISUM_RAW_W-1:0] c_iclamp;
    logic [MUL_B_W-1:0]           c_iclamp_mag;
    logic signed [SUM_W-1:0]      c_term;
    logic                         c_d_sat;
    logic [D_MAG_W-1:0]           c_d_mag;
    logic signed [SUM_W-1:0]      c_d_term;
    logic signed [SUM_W-1:0]      c_olim;
    logic signed [SUM_W-1:0]      c_out_clamp;
    logic                         c_in_acc;

    assign c_tgt  = $signed(s_axis_tdata[VAL_W-1:0]);
    assign c_meas = $signed(s_axis_tdata[2*VAL_W-1:VAL_W]);
    assign c_dt   = s_axis_tdata[2*VAL_W+DT_W-1:2*VAL_W];

    assign c_in_acc = s_axis_tvalid && s_axis_tready;

    // error and its change against the previous word
    assign c_err  = ERR_W'(c_tgt) - ERR_W'(c_meas);
    assign c_diff = DIFF_W'(c_err) - DIFF_W'(r_last_err);

    // integral increment: |err| * dt / 2^16, truncated toward zero
    assign c_inc = $signed(ISUM_RAW_W'(w_prod >> DT_FRAC));

    // anti-windup clamp of the new integral sum
    assign c_ilim   = $signed(ISUM_RAW_W'(r_integ_limit));
    assign c_iclamp = (r_isum_raw > c_ilim)  ? c_ilim  :
                      (r_isum_raw < -c_ilim) ? -c_ilim : r_isum_raw;
    assign c_iclamp_mag = c_iclamp[ISUM_RAW_W-1] ? MUL_B_W'(-c_iclamp)
                                                 : MUL_B_W'(c_iclamp);

    // gain product back to F fraction bits (P and I terms)
    assign c_term = $signed(SUM_W'(w_prod >> FRAC_BITS));

    // derivative magnitude, saturated where it cannot affect the clamped output
    assign c_d_sat  = (w_quot >> D_SAT_SHIFT) != '0;
    assign c_d_mag  = c_d_sat ? (D_MAG_W'(1) << D_SAT_SHIFT) : D_MAG_W'(w_quot);
    assign c_d_term = $signed(SUM_W'(c_d_mag));

    // output clamp
    assign c_olim      = $signed(SUM_W'(r_output_limit));
    assign c_out_clamp = (r_sum > c_olim)  ? c_olim  :
                         (r_sum < -c_olim) ? -c_olim : r_sum;

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_deriv_gain   <= '0;
            r_integ_limit  <= ILIM_RST;
            r_output_limit <= OLIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN: begin
                    r_prop_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_INTEG_GAIN: begin
                    r_integ_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_DERIV_GAIN: begin
                    r_deriv_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_INTEG_LIMIT: begin
                    r_integ_limit <= i_cfg_wdata;
                end
                REG_OUTPUT_LIMIT: begin
                    r_output_limit <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer: state, integral and last error, unit starts, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_integ_sum     <= '0;
            r_last_err      <= '0;
            r_mul_req.start <= 1'b0;
            r_div_start     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // one-cycle start pulses for the serial units
            r_mul_req.start <= (r_state == S_IDLE && c_in_acc)
                            || (r_state == S_P && w_mul_sts.done)
                            || (r_state == S_ICLAMP)
                            || (r_state == S_I && w_mul_sts.done && r_dt != '0);
            r_div_start     <= (r_state == S_D) && w_mul_sts.done;
            // a held word stays until taken, the finished one is loaded in S_OUT
            r_out_valid     <= (r_state == S_OUT) || (r_out_valid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (c_in_acc) begin
                        r_err_mag   <= c_err[ERR_W-1] ? ERR_W'(-c_err) : ERR_W'(c_err);
                        r_err_neg   <= c_err[ERR_W-1];
                        r_diff_mag  <= c_diff[DIFF_W-1] ? DIFF_W'(-c_diff)
                                                        : DIFF_W'(c_diff);
                        r_diff_neg  <= c_diff[DIFF_W-1];
                        r_dt        <= c_dt;
                        r_last_err  <= c_err;
                        // proportional product first
                        r_mul_req.a     <= r_prop_gain;
                        r_mul_req.b     <= c_err[ERR_W-1] ? MUL_B_W'(-c_err)
                                                          : MUL_B_W'(c_err);
                        r_state <= S_P;
                    end
                end
                S_P: begin
                    if (w_mul_sts.done) begin
                        r_sum <= r_err_neg ? -c_term : c_term;
                        // integral increment |err| * dt
                        r_mul_req.a     <= MUL_A_W'(r_dt);
                        r_mul_req.b     <= MUL_B_W'(r_err_mag);
                        r_state         <= S_INC;
                    end
                end
                S_INC: begin
                    if (w_mul_sts.done) begin
                        r_isum_raw <= r_err_neg ? ISUM_RAW_W'(r_integ_sum) - c_inc
                                                : ISUM_RAW_W'(r_integ_sum) + c_inc;
                        r_state    <= S_ICLAMP;
                    end
                end
                S_ICLAMP: begin
                    r_integ_sum     <= ISUM_W'(c_iclamp);
                    r_isum_neg      <= c_iclamp[ISUM_RAW_W-1];
                    r_mul_req.a     <= r_integ_gain;
                    r_mul_req.b     <= c_iclamp_mag;
                    r_state         <= S_I;
                end
                S_I: begin
                    if (w_mul_sts.done) begin
                        r_sum <= r_isum_neg ? r_sum - c_term : r_sum + c_term;
                        if (r_dt != '0) begin
                            r_mul_req.a     <= r_deriv_gain;
                            r_mul_req.b     <= r_diff_mag;
                            r_state         <= S_D;
                        end else begin
                            // zero step time: no derivative term
                            r_state <= S_OUT;
                        end
                    end
                end
                S_D: begin
                    if (w_mul_sts.done) begin
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_sum   <= r_diff_neg ? r_sum - c_d_term : r_sum + c_d_term;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= VAL_W'(c_out_clamp);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pwc_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    // the divider reads the derivative product held in the multiplier
    pwc_ser_div #(
        .DIVD_W (DIVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (DIVD_W'({w_prod[PROD_W-2:0], {DT_FRAC{1'b0}}} >> FRAC_BITS)),
        .i_divisor  (r_dt),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

endmodule

`default_nettype wire

[rtl/pwc_ser_mul.sv]
// ----------------------------------------------------------------------------
// pwc_ser_mul
// shift-add multiplier, one bit of the a operand per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_ser_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pwc_pkg::t_mul_req          i_req,
    output pwc_pkg::t_unit_sts              o_sts,
    output logic [pwc_pkg::PROD_W-1:0]      o_prod
);
    import pwc_pkg::*;

    localparam int CNT_W = $clog2(MUL_A_W);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_B_W:0]   n_upper;

    // add the multiplicand into the top half, then shift the product right
    assign n_upper = {1'b0, r_acc[PROD_W-1:MUL_A_W]} + (r_a[0] ? {1'b0, r_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(MUL_A_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_A_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a >> 1;
            r_acc <= {n_upper, r_acc[MUL_A_W-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

`default_nettype wire

[rtl/pwc_ser_div.sv]
// ----------------------------------------------------------------------------
// pwc_ser_div
// restoring divider by the step time, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_ser_div #(
    parameter int DIVD_W = 56
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [DIVD_W-1:0]         i_dividend,
    input  wire logic [pwc_pkg::DT_W-1:0]  i_divisor,
    output pwc_pkg::t_unit_sts             o_sts,
    output logic [DIVD_W-1:0]              o_quot
);
    import pwc_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic [DIVD_W-1:0] r_q;
    logic [DT_W-1:0]   r_rem;
    logic [DT_W-1:0]   r_dv;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DT_W:0]     c_trial;
    logic              c_fit;
    logic [DT_W-1:0]   n_rem;

    // dividend bits leave at the top while quotient bits enter at the bottom
    assign c_trial = {r_rem, r_q[DIVD_W-1]};
    assign c_fit   = c_trial >= {1'b0, r_dv};
    assign n_rem   = c_fit ? DT_W'(c_trial - {1'b0, r_dv}) : c_trial[DT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(DIVD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVD_W-2:0], c_fit};
            r_rem <= n_rem;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

`default_nettype wire

[rtl/pwc_checker.sv]
// ----------------------------------------------------------------------------
// pwc_checker
// port-level checks of the pid block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_with_integral_clamp_assert.svh"

module pwc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // a held result word stays offered
    `PWC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped")

    // one word at a time: the input closes right after a word is taken
    `PWC_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")

    // the clamp limit is below 2^30, so the most negative code never appears
    `PWC_ASSERT_IMP(a_clamp_range, m_axis_tvalid, !(m_axis_tdata[30] && (m_axis_tdata[29:0] == 30'd0)) && !m_axis_tdata[31], "output outside clamp range")

    // after reset the block is ready with nothing pending
    `PWC_ASSERT_RST(a_reset_state, !i_rst_n, s_axis_tready && !m_axis_tvalid, "bad state after reset")

endmodule

bind pid_with_integral_clamp pwc_checker u_pwc_checker (.*);

`default_nettype wire

[tb/pid_with_integral_clamp_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_integral_clamp_test
// Self-checking bench for the fixed-point PID step with integral and output
// clamps. Words go in on the input stream and the bench predicts each control
// value from its own copy of the gains, limits, integral sum and last error.
// It checks every output word in order; random phases stall both sides.
// ----------------------------------------------------------------------------

module pid_with_integral_clamp_test;

    import pwc_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_LIMIT    = 4000;   // latency + longest gap + longest stall, well over
    localparam int FLUSH_CYCLES  = 250;
    localparam int REG_COUNT     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_OUTPUT_LIMIT + 3'd1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 31'sh3FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 31'sh4000_0000;
    localparam logic [DT_W-1:0]         DT_MAX  = 16'hFFFF;
    localparam logic [LIM_W-1:0]        ALL_ONES = 30'h3FFF_FFFF;  // gains keep the low 24 bits
    localparam logic [LIM_W-1:0]        ONE_Q16  = 30'h0001_0000;

    // one input word, last field in the lowest bits
    typedef struct packed {
        logic [DT_W-1:0]         step_time;
        logic signed [VAL_W-1:0] measured;
        logic signed [VAL_W-1:0] target;
    } pid_sample_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [30:0] target_value, [61:31] measured_value, [77:62] step_time, [79:78] zero
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [30:0] control_out, [31] zero
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [LIM_W-1:0]        i_cfg_wdata = '0;

    pid_with_integral_clamp #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // words waiting to go out, control values waiting to come back
    pid_sample_t      sample_queue[$];
    logic [VAL_W-1:0] ctrl_expected[$];

    // bench copy of the registers, reset values
    longint kp = 0;
    longint ki = 0;
    longint kd = 0;
    longint integ_lim = longint'(100) << FRAC_BITS;
    longint out_lim = longint'(500) << FRAC_BITS;

    // bench copy of the loop state
    longint integ_acc = 0;
    longint prev_err = 0;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  in_hold = 0;
    int  out_hold = 0;
    bit  in_idle_on = 1'b0;
    bit  out_idle_on = 1'b0;

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // gain * v / 2^sh with truncation toward zero, gain never negative
    function automatic longint scale_trunc(longint gain, longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (gain * m) >> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // one PID step: updates the integral and last error, returns control_out
    function automatic logic [VAL_W-1:0] pid_predict(pid_sample_t s);
        longint tgt, meas, dt, err, p_term, i_term, d_term, diff, m, den, q, r, dm, total;
        tgt  = $signed(s.target);
        meas = $signed(s.measured);
        dt   = s.step_time;
        err  = tgt - meas;

        p_term = scale_trunc(kp, err, FRAC_BITS);

        // anti-windup: the fresh sum is clamped before the I term uses it
        integ_acc = clamp_sym(integ_acc + scale_trunc(dt, err, DT_FRAC), integ_lim);
        i_term = scale_trunc(ki, integ_acc, FRAC_BITS);

        // derivative off for a zero step time, last error still moves on
        d_term = 0;
        if (dt != 0) begin
            diff = err - prev_err;
            m    = kd * ((diff < 0) ? -diff : diff);
            den  = dt << FRAC_BITS;
            q    = m / den;
            r    = m % den;
            if (q >= (longint'(1) << (D_SAT_SHIFT - DT_FRAC)))
                dm = longint'(1) << D_SAT_SHIFT;
            else
                dm = (q << DT_FRAC) + (r << DT_FRAC) / den;
            d_term = (diff < 0) ? -dm : dm;
        end
        prev_err = err;

        total = clamp_sym(p_term + i_term + d_term, out_lim);
        return total[VAL_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // gap length: mostly short, now and then long enough to outlast a whole step
    function automatic int draw_gap();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic signed [VAL_W-1:0] draw_extreme();
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // mostly a loop near its setpoint, some noise, some extremes, some dt = 0
    function automatic pid_sample_t draw_sample(longint setpoint);
        pid_sample_t s;
        int          pick;
        s.target    = VAL_W'($urandom);
        s.measured  = VAL_W'($urandom);
        s.step_time = DT_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick >= 3) begin
            s.target   = VAL_W'(setpoint);
            s.measured = VAL_W'(setpoint + longint'($urandom_range(0, 40 << 16))
                                - (longint'(20) << 16));
            s.step_time = (pick == 3) ? '0 : DT_W'($urandom_range(1, 16'h0800));
        end else if (pick == 2) begin
            s.target   = draw_extreme();
            s.measured = draw_extreme();
            case ($urandom_range(0, 2))
                0: s.step_time = '0;
                1: s.step_time = 16'h0001;
                default: s.step_time = DT_MAX;
            endcase
        end
        return s;
    endfunction

    function automatic logic [LIM_W-1:0] draw_setting(logic [CFG_IDX_W-1:0] idx);
        bit is_gain;
        is_gain = (idx <= REG_DERIV_GAIN);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return LIM_W'($urandom);      // gain bits above 24 land here too
            default: return is_gain ? LIM_W'($urandom_range(0, 8 << 16))
                                    : LIM_W'($urandom_range(0, 1000 << 16));
        endcase
    endfunction

    task automatic add_sample(logic signed [VAL_W-1:0] tgt, logic signed [VAL_W-1:0] meas,
                              logic [DT_W-1:0] dt);
        pid_sample_t s;
        s.target    = tgt;
        s.measured  = meas;
        s.step_time = dt;
        sample_queue.push_back(s);
    endtask

    // one register write; we stays high across back-to-back writes
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_PROP_GAIN:    kp = data[GAIN_W-1:0];
            REG_INTEG_GAIN:   ki = data[GAIN_W-1:0];
            REG_DERIV_GAIN:   kd = data[GAIN_W-1:0];
            REG_INTEG_LIMIT:  integ_lim = data;
            REG_OUTPUT_LIMIT: out_lim = data;
            default: ;        // unmapped index, dropped by the block
        endcase
    endtask

    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender holds off until every word is back
    task automatic wait_drained();
        @(posedge i_clk);
        while (sample_queue.size() != 0 || ctrl_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic randomize_settings(bit write_all);
        for (int k = 0; k < REG_COUNT; k++) begin
            if (write_all || $urandom_range(0, 1) == 1)
                cfg_write(CFG_IDX_W'(k), draw_setting(CFG_IDX_W'(k)));
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNMAPPED + CFG_IDX_W'($urandom_range(0, 2)), LIM_W'($urandom));
        cfg_close();
    endtask

    // ------------------------------------------------------------------------
    // input side: driver at the falling edge, handshake seen at the rising edge
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_hold > 0) begin
            in_hold = in_hold - 1;
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
        end else if (sample_queue.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {2'b00, sample_queue[0]};
        end else begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
        end
    end

    // predict from the word that was actually on the bus
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            ctrl_expected.push_back(pid_predict(pid_sample_t'(s_axis_tdata[77:0])));
            void'(sample_queue.pop_front());
            if (in_idle_on && $urandom_range(0, 2) == 0)
                in_hold = draw_gap();
        end
    end

    // ------------------------------------------------------------------------
    // output side: random back-pressure and the checker
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold = out_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 15) == 0) begin
            out_hold = draw_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [VAL_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ctrl_expected.size() == 0) begin
                $display("%0t: control_out %0d with nothing expected", $time,
                         $signed(m_axis_tdata[VAL_W-1:0]));
                mismatch_count++;
            end else begin
                want = ctrl_expected.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want) begin
                    $display("%0t: control_out expected %0d, got %0d", $time,
                             $signed(want), $signed(m_axis_tdata[VAL_W-1:0]));
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial begin
        int     n_random;
        int     n_phase;
        longint setpoint;

        n_random = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no gains, so zero out, but the integral still winds up
        add_sample(VAL_MAX, VAL_MIN, DT_MAX);
        add_sample(VAL_MIN, VAL_MAX, DT_MAX);
        add_sample('0, '0, '0);
        wait_drained();

        // modest gains, reset limits kept; gain bits above 24 and a stray index
        cfg_write(REG_PROP_GAIN, {6'h2A, 24'h01_0000});
        cfg_write(REG_INTEG_GAIN, 30'h0000_8000);
        cfg_write(REG_DERIV_GAIN, 30'h0000_4000);
        cfg_write(REG_UNMAPPED, ALL_ONES);
        cfg_close();
        add_sample(VAL_MAX, VAL_MIN, DT_MAX);
        add_sample(VAL_MIN, VAL_MAX, DT_MAX);
        add_sample(31'sd1000 <<< 16, '0, '0);          // zero step time
        add_sample('0, '0, 16'h0001);
        add_sample('0, 31'sd1, 16'h0001);              // tiny negative error, its integral increment truncates to 0
        add_sample(31'sd5, '0, 16'h8000);
        add_sample(VAL_MIN, VAL_MIN, 16'h1234);        // zero error
        add_sample(VAL_MAX, VAL_MAX, 16'h0001);
        add_sample('0, VAL_MAX, 16'h0001);
        add_sample(VAL_MAX, '0, 16'h0001);
        wait_drained();

        // every register at its top value, largest derivative swings
        cfg_write(REG_PROP_GAIN, ALL_ONES);
        cfg_write(REG_INTEG_GAIN, ALL_ONES);
        cfg_write(REG_DERIV_GAIN, ALL_ONES);
        cfg_write(REG_INTEG_LIMIT, ALL_ONES);
        cfg_write(REG_OUTPUT_LIMIT, ALL_ONES);
        cfg_close();
        add_sample(VAL_MAX, VAL_MIN, 16'h0001);
        add_sample(VAL_MIN, VAL_MAX, 16'h0001);
        add_sample(VAL_MAX, VAL_MIN, '0);
        add_sample(VAL_MIN, VAL_MAX, DT_MAX);
        add_sample('0, '0, DT_MAX);
        wait_drained();

        // both limits at zero
        cfg_write(REG_INTEG_LIMIT, '0);
        cfg_write(REG_OUTPUT_LIMIT, '0);
        cfg_close();
        add_sample(VAL_MAX, VAL_MIN, DT_MAX);
        add_sample(VAL_MIN, VAL_MAX, 16'h0001);
        wait_drained();

        // wind the integral up, then pull its limit below the held sum
        cfg_write(REG_INTEG_GAIN, ONE_Q16);
        cfg_write(REG_INTEG_LIMIT, ALL_ONES);
        cfg_write(REG_OUTPUT_LIMIT, ALL_ONES);
        cfg_close();
        add_sample(VAL_MAX, '0, DT_MAX);
        add_sample(VAL_MAX, '0, DT_MAX);
        wait_drained();
        cfg_write(REG_INTEG_LIMIT, 30'd5 << 16);
        cfg_close();
        add_sample('0, '0, '0);
        wait_drained();

        // random phases, each with its own settings and stall pattern
        while (n_random < RANDOM_ITEMS) begin
            randomize_settings(n_random == 0);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            setpoint = longint'($urandom_range(0, 600 << 16)) - (longint'(300) << 16);
            n_phase = $urandom_range(20, 150);
            repeat (n_phase) sample_queue.push_back(draw_sample(setpoint));
            n_random += n_phase;
            wait_drained();
        end

        // let any stray word show up before the verdict
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
